@@ design/bhpq_pkg.sv @@
// Shared types and constants for the binary heap priority queue.
// Request/result payload structs, default sizes, opcode and status codes.
// No dependencies.
package bhpq_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [6:0]         entry_count;
    logic [1:0]         op_status;
  } out_rsp_t;

endpackage

@@ design/binary_heap_priority_queue.sv @@
// Binary heap priority queue: push / pop over a one-port heap RAM, min or max order.
// Push: climbs from the new last slot toward the root, UP_CHK then UP_CMP per level;
//   pop: moves the last entry to the root (LD_WAIT), then sinks it, DN_CHK, DN_RDR and
//   DN_CMP per level; errors and a pop of the last entry never raise busy.
// Result strobe in the cycle busy drops, cannot be stalled; next request accepted there.
// Sync active-low reset empties the heap, selects min order. Needs bhpq_pkg, bhpq_ram.
module binary_heap_priority_queue #(
  parameter int CAPACITY    = bhpq_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bhpq_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bhpq_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output bhpq_pkg::out_rsp_t out_rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    IDLE, UP_CHK, UP_CMP, LD_WAIT, DN_CHK, DN_RDR, DN_CMP
  } state_t;

  typedef enum logic [1:0] {SEL_NONE, SEL_LEFT, SEL_RIGHT} sel_t;

  state_t             state_r, state_nxt;
  sel_t               bsel_r, bsel_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               mode_r, mode_nxt;
  logic [VW-1:0]      cur_r, cur_nxt;
  logic [VW-1:0]      best_r, best_nxt;
  logic [VW-1:0]      root_r, root_nxt;
  logic [VW-1:0]      popped_r, popped_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  bhpq_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [VW-1:0]      ram_wdata, ram_rdata;

  logic [VW-1:0]      cmp_a, cmp_b, cmp_x, cmp_y;
  logic               above;
  logic               emit;
  logic [XW-1:0]      lc_x, rc_x, cnt_x;
  logic [AW-1:0]      parent;
  logic [VW+31:0]     vin_ext, pop_ext, top_ext;
  logic [CW+6:0]      cnt_ext;

  bhpq_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared compare: a ranks strictly above b
  assign cmp_x = mode_r ? cmp_b : cmp_a;
  assign cmp_y = mode_r ? cmp_a : cmp_b;
  assign above = $signed(cmp_x) < $signed(cmp_y);

  assign lc_x    = {1'b0, pos_r, 1'b1};
  assign rc_x    = lc_x + XW'(1);
  assign cnt_x   = XW'(count_r);
  assign parent  = AW'((pos_r - AW'(1)) >> 1);
  assign vin_ext = {VW'(0), in_req.value};

  assign busy       = state_r != IDLE;
  assign cfg_ready  = !busy;
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  always_comb begin
    cmp_a = cur_r;
    cmp_b = ram_rdata;
    case (state_r)
      DN_RDR: begin
        cmp_a = ram_rdata;
        cmp_b = cur_r;
      end
      DN_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = best_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    bsel_nxt   = bsel_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    cur_nxt    = cur_r;
    best_nxt   = best_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_addr   = pos_r;
    ram_wdata  = cur_r;
    emit       = 1'b0;

    case (state_r)
      IDLE: begin
        if (cfg_valid && count_r == '0) begin
          mode_nxt = cfg_data;
        end
        if (start) begin
          popped_nxt = '1;
          status_nxt = bhpq_pkg::STAT_DONE;
          if (in_req.opcode == bhpq_pkg::OP_PUSH) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = bhpq_pkg::STAT_FULL;
              emit       = 1'b1;
            end else begin
              cur_nxt   = vin_ext[VW-1:0];
              pos_nxt   = AW'(count_r);
              count_nxt = count_r + CW'(1);
              state_nxt = UP_CHK;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bhpq_pkg::STAT_EMPTY;
              emit       = 1'b1;
            end else begin
              popped_nxt = root_r;
              count_nxt  = count_r - CW'(1);
              ram_addr   = AW'(count_r - CW'(1));
              if (count_r == CW'(1)) begin
                emit = 1'b1;
              end else begin
                state_nxt = LD_WAIT;
              end
            end
          end
        end
      end
      UP_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          emit      = 1'b1;
          state_nxt = IDLE;
        end else begin
          ram_addr  = parent;
          state_nxt = UP_CMP;
        end
      end
      UP_CMP: begin
        ram_we = 1'b1;
        if (above) begin
          ram_wdata = ram_rdata;
          pos_nxt   = parent;
          state_nxt = UP_CHK;
        end else begin
          emit      = 1'b1;
          state_nxt = IDLE;
        end
      end
      LD_WAIT: begin
        cur_nxt   = ram_rdata;
        pos_nxt   = '0;
        state_nxt = DN_CHK;
      end
      DN_CHK: begin
        if (lc_x >= cnt_x) begin
          ram_we    = 1'b1;
          emit      = 1'b1;
          state_nxt = IDLE;
        end else begin
          ram_addr  = lc_x[AW-1:0];
          state_nxt = DN_RDR;
        end
      end
      DN_RDR: begin
        ram_addr = rc_x[AW-1:0];
        if (above) begin
          best_nxt = ram_rdata;
          bsel_nxt = SEL_LEFT;
        end else begin
          best_nxt = cur_r;
          bsel_nxt = SEL_NONE;
        end
        state_nxt = DN_CMP;
      end
      DN_CMP: begin
        ram_we = 1'b1;
        if (rc_x < cnt_x && above) begin
          ram_wdata = ram_rdata;
          pos_nxt   = rc_x[AW-1:0];
          state_nxt = DN_CHK;
        end else if (bsel_r == SEL_LEFT) begin
          ram_wdata = best_r;
          pos_nxt   = lc_x[AW-1:0];
          state_nxt = DN_CHK;
        end else begin
          emit      = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase

    root_nxt = root_r;
    if (ram_we && ram_addr == '0) begin
      root_nxt = ram_wdata;
    end

    pop_ext = {{32{popped_nxt[VW-1]}}, popped_nxt};
    top_ext = {{32{root_nxt[VW-1]}}, root_nxt};
    cnt_ext = {7'd0, count_nxt};

    out_strobe_nxt           = emit;
    out_rsp_nxt              = out_rsp_r;
    if (emit) begin
      out_rsp_nxt.popped_value = pop_ext[31:0];
      out_rsp_nxt.top_value    = (count_nxt != '0) ? top_ext[31:0] : '1;
      out_rsp_nxt.top_valid    = count_nxt != '0;
      out_rsp_nxt.entry_count  = cnt_ext[6:0];
      out_rsp_nxt.op_status    = status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bsel_r    <= bsel_nxt;
    pos_r     <= pos_nxt;
    cur_r     <= cur_nxt;
    best_r    <= best_nxt;
    root_r    <= root_nxt;
    popped_r  <= popped_nxt;
    status_r  <= status_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (!rst_n) begin
      state_r      <= IDLE;
      count_r      <= '0;
      mode_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      mode_r       <= mode_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("count above capacity");

  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe) else $error("request dropped");

  a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_rsp.op_status == bhpq_pkg::STAT_EMPTY |-> !out_rsp.top_valid)
    else $error("empty pop reports a top");

  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |=> $stable(mode_r)) else $error("order changed under entries");

endmodule

@@ design/bhpq_ram.sv @@
// Generic single-port RAM with registered read data.
// Used for heap storage; no dependencies.
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sim/tb_binary_heap_priority_queue.sv @@
// Self-checking testbench for binary_heap_priority_queue: a directed table, then random
// push/pop phases under both orders, checked against an in-bench heap model.
// Depends on bhpq_pkg and the binary_heap_priority_queue RTL.
module tb_binary_heap_priority_queue;

  localparam int HEAP_DEPTH  = bhpq_pkg::CAPACITY_DEF;
  localparam int ITEM_TARGET = 1500;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 30;
  localparam int DIR_ROWS    = 29;
  localparam int EXP_DEPTH   = 8;

  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] NONE = -32'sd1;

  typedef enum logic [1:0] {ROW_PUSH, ROW_POP, ROW_MODE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic signed [31:0] value;
    logic               fixed_exp;
    bhpq_pkg::out_rsp_t rsp;
  } dir_row_t;

  localparam bhpq_pkg::out_rsp_t NO_RSP = '0;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  bhpq_pkg::in_req_t  in_req    = '0;
  logic               out_strobe;
  bhpq_pkg::out_rsp_t out_rsp;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;

  logic signed [31:0] heap_vals [HEAP_DEPTH];
  int                 heap_cnt  = 0;
  logic               heap_max  = 1'b0;
  bhpq_pkg::out_rsp_t exp_q [EXP_DEPTH];
  logic [2:0]         exp_wr       = '0;
  logic [2:0]         exp_rd       = '0;
  int                 mismatches   = 0;
  int                 stall_cycles = 0;
  int                 items_sent   = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_POP,  32'sd0, 1'b1, '{NONE, NONE, 1'b0, 7'd0, bhpq_pkg::STAT_EMPTY}},
    '{ROW_PUSH, VMAX,   1'b1, '{NONE, VMAX, 1'b1, 7'd1, bhpq_pkg::STAT_DONE}},
    '{ROW_POP,  32'sd0, 1'b1, '{VMAX, NONE, 1'b0, 7'd0, bhpq_pkg::STAT_DONE}},
    '{ROW_PUSH, VMIN,   1'b1, '{NONE, VMIN, 1'b1, 7'd1, bhpq_pkg::STAT_DONE}},
    '{ROW_PUSH, VMAX,   1'b0, NO_RSP},
    '{ROW_PUSH, 32'sd0, 1'b0, NO_RSP},
    '{ROW_PUSH, NONE,   1'b0, NO_RSP},
    '{ROW_PUSH, 32'sd5, 1'b0, NO_RSP},
    '{ROW_PUSH, 32'sd5, 1'b0, NO_RSP},
    '{ROW_PUSH, 32'sd5, 1'b0, NO_RSP},
    '{ROW_MODE, 32'sd1, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b1, '{NONE, NONE, 1'b0, 7'd0, bhpq_pkg::STAT_EMPTY}},
    '{ROW_MODE, 32'sd1, 1'b0, NO_RSP},
    '{ROW_PUSH, VMIN,   1'b1, '{NONE, VMIN, 1'b1, 7'd1, bhpq_pkg::STAT_DONE}},
    '{ROW_PUSH, VMAX,   1'b0, NO_RSP},
    '{ROW_PUSH, NONE,   1'b0, NO_RSP},
    '{ROW_PUSH, VMAX,   1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_POP,  32'sd0, 1'b0, NO_RSP},
    '{ROW_MODE, 32'sd0, 1'b0, NO_RSP}
  };

  binary_heap_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // strict ordering only: equal values never move past each other
  function automatic logic outranks(logic signed [31:0] a, logic signed [31:0] b);
    return heap_max ? (a > b) : (a < b);
  endfunction

  function automatic bhpq_pkg::out_rsp_t heap_apply(logic op, logic signed [31:0] v);
    bhpq_pkg::out_rsp_t r;
    int                 pos;
    int                 nxt;
    int                 lc;
    int                 rc;
    logic               done;
    logic signed [31:0] t;
    r.popped_value = NONE;
    r.op_status    = bhpq_pkg::STAT_DONE;
    if (op == bhpq_pkg::OP_PUSH) begin
      if (heap_cnt >= HEAP_DEPTH) begin
        r.op_status = bhpq_pkg::STAT_FULL;
      end else begin
        heap_vals[heap_cnt] = v;
        pos = heap_cnt;
        heap_cnt++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          nxt = (pos - 1) / 2;
          if (outranks(heap_vals[pos], heap_vals[nxt])) begin
            t = heap_vals[pos]; heap_vals[pos] = heap_vals[nxt]; heap_vals[nxt] = t;
            pos = nxt;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else if (heap_cnt == 0) begin
      r.op_status = bhpq_pkg::STAT_EMPTY;
    end else begin
      r.popped_value = heap_vals[0];
      heap_cnt--;
      heap_vals[0] = heap_vals[heap_cnt];
      pos = 0;
      done = 1'b0;
      while (!done) begin
        nxt = pos;
        lc  = 2 * pos + 1;
        rc  = 2 * pos + 2;
        if (lc < heap_cnt && outranks(heap_vals[lc], heap_vals[nxt])) nxt = lc;
        if (rc < heap_cnt && outranks(heap_vals[rc], heap_vals[nxt])) nxt = rc;
        if (nxt == pos) begin
          done = 1'b1;
        end else begin
          t = heap_vals[pos]; heap_vals[pos] = heap_vals[nxt]; heap_vals[nxt] = t;
          pos = nxt;
        end
      end
    end
    r.top_valid   = (heap_cnt != 0);
    r.top_value   = (heap_cnt != 0) ? heap_vals[0] : NONE;
    r.entry_count = 7'(heap_cnt);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return VMIN;
        1: return VMAX;
        2: return 32'sd0;
        default: return NONE;
      endcase
    end
    if (r < 4) return $signed($urandom_range(0, 16)) - 32'sd8;
    return $signed($urandom);
  endfunction

  // start stays high across back-to-back requests when gap is zero
  task automatic issue_request(input logic op, input logic signed [31:0] v,
                               input logic use_fixed, input bhpq_pkg::out_rsp_t fixed_rsp,
                               input int gap);
    bhpq_pkg::out_rsp_t pred;
    start  <= 1'b1;
    in_req <= {op, v};
    do @(posedge clk); while (busy);
    pred = heap_apply(op, v);
    exp_q[exp_wr] = use_fixed ? fixed_rsp : pred;
    exp_wr = exp_wr + 3'd1;
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_mode(input logic m);
    if (start) start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    if (heap_cnt == 0) heap_max = m;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    bhpq_pkg::out_rsp_t want;
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_binary_heap_priority_queue failed");
      $finish;
    end else if (rst_n && out_strobe) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $time);
      end else begin
        want = exp_q[exp_rd];
        exp_rd = exp_rd + 3'd1;
        if (want !== out_rsp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp pop=%0d top=%0d vld=%b cnt=%0d st=%0d",
                     $time, want.popped_value, want.top_value, want.top_valid,
                     want.entry_count, want.op_status);
            $display("                 got pop=%0d top=%0d vld=%b cnt=%0d st=%0d",
                     out_rsp.popped_value, out_rsp.top_value, out_rsp.top_valid,
                     out_rsp.entry_count, out_rsp.op_status);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int   k;
    int   phase_len;
    int   push_pct;
    logic burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      case (dir_tab[k].kind)
        ROW_MODE: write_mode(dir_tab[k].value[0]);
        ROW_PUSH: issue_request(bhpq_pkg::OP_PUSH, dir_tab[k].value, dir_tab[k].fixed_exp,
                                dir_tab[k].rsp, pick_gap());
        default:  issue_request(bhpq_pkg::OP_POP, dir_tab[k].value, dir_tab[k].fixed_exp,
                                dir_tab[k].rsp, pick_gap());
      endcase
    end

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        while (heap_cnt > 0)
          issue_request(bhpq_pkg::OP_POP, pick_value(), 1'b0, NO_RSP, pick_gap());
        if ($urandom_range(0, 1))
          issue_request(bhpq_pkg::OP_POP, pick_value(), 1'b0, NO_RSP, pick_gap());
      end
      if ($urandom_range(0, 1)) write_mode(1'($urandom_range(0, 1)));
      phase_len = $urandom_range(20, 150);
      case ($urandom_range(0, 3))
        0: push_pct = 20;
        1: push_pct = 50;
        2: push_pct = 80;
        default: push_pct = 95;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len; k++)
        issue_request(($urandom_range(0, 99) < push_pct) ? bhpq_pkg::OP_PUSH
                                                           : bhpq_pkg::OP_POP,
                      pick_value(), 1'b0, NO_RSP, burst ? 0 : pick_gap());
    end

    if (start) start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_binary_heap_priority_queue passed");
    end else begin
      $display("tb_binary_heap_priority_queue failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/bhpq_pkg.sv
design/bhpq_ram.sv
design/binary_heap_priority_queue.sv
sim/tb_binary_heap_priority_queue.sv
